>>> hw/rtl/nfsa_pkg.sv
// Shared types and constants of the next-fit slot allocator.
package nfsa_pkg;

	// Flags are stored as words of this many slots.
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;

	// Field widths of the transactions and the register.
	localparam int CFG_W    = 9;
	localparam int IDX_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// Register port widths.
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// Register indexes, taken from the word address bit of paddr.
	localparam logic REG_ACTIVE_SLOTS = 1'b0;

	localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = 9'd256;

	// Input modes.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_CHECK
	} fsm_t;

	// Result of scanning one flag word for a free slot.
	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] pos;
	} scan_res_t;

endpackage

>>> hw/rtl/nfsa_in_if.sv
// Request channel of the slot allocator: mode and slot index.
interface nfsa_in_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [nfsa_pkg::IDX_W-1:0] slot_index;

	modport source (output valid, mode, slot_index, input ready);
	modport sink (input valid, mode, slot_index, output ready);
endinterface

>>> hw/rtl/nfsa_out_if.sv
// Response channel of the slot allocator: granted slot, status and count.
interface nfsa_out_if;
	logic                          valid;
	logic                          ready;
	logic [nfsa_pkg::IDX_W-1:0]    granted_slot;
	logic [nfsa_pkg::STATUS_W-1:0] status;
	logic [nfsa_pkg::COUNT_W-1:0]  used_count;

	modport source (output valid, granted_slot, status, used_count, input ready);
	modport sink (input valid, granted_slot, status, used_count, output ready);
endinterface

>>> hw/rtl/nfsa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module nfsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hw/rtl/nfsa_scan.sv
// Finds the lowest free slot of one flag word within a window of bit positions.
module nfsa_scan (
	input  logic [nfsa_pkg::WORD_W-1:0] data,
	input  logic [nfsa_pkg::BIT_W-1:0]  lo,
	input  logic                        is_last,
	input  logic [nfsa_pkg::BIT_W-1:0]  last_bit,
	output nfsa_pkg::scan_res_t         res
);
	import nfsa_pkg::*;

	logic [WORD_W-1:0] mask_lo;
	logic [WORD_W-1:0] mask_hi;
	logic [WORD_W-1:0] avail;

	// Bits below the start position and past the last active slot are excluded.
	assign mask_lo = {WORD_W{1'b1}} << lo;
	assign mask_hi = is_last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit))
	                         : {WORD_W{1'b1}};
	assign avail   = ~data & mask_lo & mask_hi;

	always_comb begin
		res = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (avail[i]) begin
				res.hit = 1'b1;
				res.pos = BIT_W'(i);
			end
		end
	end
endmodule

>>> hw/rtl/next_fit_slot_allocator_top.sv
// Next-fit slot allocator: top level with flag memory, search sequencer and register port.
//
// The allocator keeps one in-use flag per slot in a RAM of 32-bit words, plus a search
// hint and a count of slots in use. An allocate transaction (mode 0) searches from the
// hint upward for a free slot, wrapping at the active slot count, and returns the index
// it marked used; when every active slot is taken it returns status 1 and changes
// nothing. A free transaction (mode 1) clears the given slot and pulls the hint down to
// it; freeing a slot that is not in use returns status 2 and changes nothing. Every
// request gives exactly one response, carrying the in-use count after the request.
// The active slot count is the register at address 0; a value of 0 acts as 1 and a value
// above MAX_SLOTS acts as MAX_SLOTS. Write it only while no request is outstanding.
// Timing: the flag RAM is read one word per cycle. A free request looks only at the
// word of its slot. An allocate request visits words from the hint's word on, wrapping,
// until it finds a free slot, at most every active word once plus the start word again.
// A new request is accepted only once the previous one has finished. The response sits
// in an output register, so a new request is accepted while the previous response waits
// to be taken; a request only stalls at its last step while that register is full and
// its response is not being taken. The flags need no clearing pass after reset: each
// flag word has a valid bit, and a word never written reads as free.
module next_fit_slot_allocator_top #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	nfsa_in_if.sink                      req,
	nfsa_out_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nfsa_pkg::PADDR_W-1:0] paddr,
	input  logic [nfsa_pkg::PDATA_W-1:0] pwdata,
	output logic [nfsa_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import nfsa_pkg::*;

	localparam int NUM_WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	// Slot positions are word index and bit index side by side.
	localparam int PW        = WADDR_W + BIT_W;
	localparam int CW        = $clog2(MAX_SLOTS + 1);
	localparam int XW0       = (CW > PW) ? CW : PW;
	// Common width for comparing the register and request fields against MAX_SLOTS.
	localparam int XW        = (XW0 > CFG_W) ? XW0 : CFG_W;

	// Control and architectural state.
	fsm_t                 state_q, state_d;
	logic [CFG_W-1:0]     active_q;
	logic [PW-1:0]        hint_q;
	logic [CW-1:0]        count_q;
	logic [NUM_WORDS-1:0] word_vld_q;

	// Request held during the search.
	logic                 mode_s1;
	logic [PW-1:0]        idx_s1;
	logic                 bad_s1;
	logic [BIT_W-1:0]     lo_s1;
	logic                 first_q;
	logic [WADDR_W-1:0]   word_q;
	logic [WADDR_W:0]     visit_q;
	logic                 vld_s1;

	// Response register.
	logic                 rsp_valid_q;
	logic [IDX_W-1:0]     granted_q;
	logic [STATUS_W-1:0]  status_q;
	logic [COUNT_W-1:0]   used_q;

	// Combinational signals.
	logic [XW-1:0]        active_x;
	logic [XW-1:0]        nm1_x;
	logic [PW-1:0]        nm1;
	logic [WADDR_W-1:0]   last_word;
	logic [BIT_W-1:0]     last_bit;
	logic [PW-1:0]        p0;
	logic [XW-1:0]        req_idx_x;
	logic [PW-1:0]        req_idx;
	logic                 req_bad;
	logic                 accept;
	logic                 rsp_block;
	logic                 visits_done;
	logic [WADDR_W-1:0]   word_next;
	logic                 finish;
	logic                 step;
	logic [WORD_W-1:0]    rdata;
	logic [WORD_W-1:0]    data_eff;
	logic [WORD_W-1:0]    wdata;
	logic                 ram_we;
	logic                 ram_re;
	logic [WADDR_W-1:0]   raddr;
	scan_res_t            scan;
	logic [PW-1:0]        hit_pos;
	logic                 free_ok;
	logic                 cfg_wr;

	// Effective count, minus one: the highest slot the search may look at.
	assign active_x  = XW'(active_q);
	assign nm1_x     = (active_x == '0) ? '0 :
	                   (active_x > XW'(MAX_SLOTS)) ? XW'(MAX_SLOTS - 1) : active_x - 1'b1;
	assign nm1       = nm1_x[PW-1:0];
	assign last_word = nm1[PW-1:BIT_W];
	assign last_bit  = nm1[BIT_W-1:0];
	// A hint left beyond the active range, after the count was lowered, restarts at zero.
	assign p0        = (hint_q <= nm1) ? hint_q : '0;

	// A free index at or beyond MAX_SLOTS can never be in use.
	assign req_idx_x = XW'(req.slot_index);
	assign req_bad   = req_idx_x >= XW'(MAX_SLOTS);
	assign req_idx   = req_idx_x[PW-1:0];

	assign accept    = req.valid && req.ready;
	assign rsp_block = rsp_valid_q && !rsp.ready;

	// The search has seen every active word once, plus the start word again for the
	// slots below the hint.
	assign visits_done = (visit_q == ((WADDR_W + 1)'(last_word) + 2'd2));
	assign word_next   = (word_q == last_word) ? '0 : word_q + 1'b1;

	// Words never written since reset hold no used slots.
	assign data_eff = vld_s1 ? rdata : '0;

	nfsa_scan u_scan (
		.data     (data_eff),
		.lo       (first_q ? lo_s1 : '0),
		.is_last  (word_q == last_word),
		.last_bit (last_bit),
		.res      (scan)
	);

	assign hit_pos = {word_q, scan.pos};
	assign free_ok = !bad_s1 && data_eff[idx_s1[BIT_W-1:0]];

	// The last cycle of a request waits only for room in the response register.
	assign finish = (state_q == S_CHECK) && !rsp_block &&
	                ((mode_s1 == MODE_FREE) || scan.hit || visits_done);
	assign step   = (state_q == S_CHECK) && (mode_s1 == MODE_ALLOC) &&
	                !scan.hit && !visits_done;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: request ready and RAM read and write controls.
	always_comb begin
		req.ready = 1'b0;
		ram_re    = 1'b0;
		raddr     = word_q;
		ram_we    = 1'b0;
		wdata     = data_eff;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				ram_re    = req.valid;
				raddr     = (req.mode == MODE_FREE) ? req_idx[PW-1:BIT_W] : p0[PW-1:BIT_W];
			end
			S_CHECK: begin
				ram_re = step;
				raddr  = word_next;
				if (mode_s1 == MODE_FREE) begin
					ram_we = finish && free_ok;
					wdata  = data_eff & ~(WORD_W'(1) << idx_s1[BIT_W-1:0]);
				end else begin
					ram_we = finish && scan.hit;
					wdata  = data_eff | (WORD_W'(1) << scan.pos);
				end
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	nfsa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_q),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			word_vld_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_re) begin
				vld_s1 <= word_vld_q[raddr];
			end
			if (ram_we) begin
				word_vld_q[word_q] <= 1'b1;
			end
		end
	end

	// Search bookkeeping.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= req.mode;
			idx_s1  <= req_idx;
			bad_s1  <= req_bad;
			lo_s1   <= p0[BIT_W-1:0];
			first_q <= 1'b1;
			word_q  <= raddr;
			visit_q <= (WADDR_W + 1)'(1);
		end else if (step) begin
			first_q <= 1'b0;
			word_q  <= word_next;
			visit_q <= visit_q + 1'b1;
		end
	end

	// Hint, count and response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				rsp_valid_q <= 1'b1;
				if (mode_s1 == MODE_ALLOC) begin
					if (scan.hit) begin
						hint_q  <= (hit_pos == nm1) ? '0 : hit_pos + 1'b1;
						count_q <= count_q + 1'b1;
					end
				end else if (free_ok) begin
					if (idx_s1 < hint_q) begin
						hint_q <= idx_s1;
					end
					count_q <= count_q - 1'b1;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			granted_q <= '0;
			status_q  <= STAT_OK;
			used_q    <= COUNT_W'(count_q);
			if (mode_s1 == MODE_ALLOC) begin
				if (scan.hit) begin
					granted_q <= IDX_W'(hit_pos);
					used_q    <= COUNT_W'(count_q + 1'b1);
				end else begin
					status_q <= STAT_FULL;
				end
			end else if (free_ok) begin
				used_q <= COUNT_W'(count_q - 1'b1);
			end else begin
				status_q <= STAT_NOT_USED;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted_slot = granted_q;
	assign rsp.status       = status_q;
	assign rsp.used_count   = used_q;

	// Register port: the write lands in the access cycle; reads and writes are always ready.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[BIT_W-3] == REG_ACTIVE_SLOTS);
	assign prdata = (paddr[BIT_W-3] == REG_ACTIVE_SLOTS) ? PDATA_W'(active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_SLOTS_RST;
		end else if (cfg_wr) begin
			active_q <= pwdata[CFG_W-1:0];
		end
	end
endmodule

>>> bench/tb.sv
// Self-checking testbench of the next-fit slot allocator.
`timescale 1ns / 1ps

module tb;
	import nfsa_pkg::*;

	localparam int SLOT_CNT = 256;
	// The slowest request visits every active flag word, and its start word again.
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS = 1700;
	localparam int MAX_PRINTS = 40;
	localparam logic [PADDR_W-1:0] ACTIVE_SLOTS_ADDR = {REG_ACTIVE_SLOTS, 2'b00};

	typedef struct {
		logic             mode;
		logic [IDX_W-1:0] slot_index;
		bit               hold_for_drain;
	} request_t;

	typedef struct {
		logic [IDX_W-1:0]    granted_slot;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  used_count;
	} grant_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	nfsa_in_if  req_if ();
	nfsa_out_if rsp_if ();

	next_fit_slot_allocator_top #(
		.MAX_SLOTS(SLOT_CNT)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Requests waiting to be driven, and the grants predicted for accepted requests.
	request_t request_queue [$];
	grant_t   grant_queue [$];

	// Requests handed to the request channel whose response has not yet come back.
	int in_flight;
	int mismatches;
	bit req_taken;
	int req_gap, req_calm, rsp_hold, rsp_calm;
	request_t cur_req;
	grant_t got_grant, want_grant;

	// Shadow copy of the allocator: flags, hint, in-use count and the register.
	logic slot_taken [SLOT_CNT];
	int next_hint;
	int taken_count;
	logic [CFG_W-1:0] active_slots_cfg;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Effective table size: the register clamped to the range 1 to SLOT_CNT.
	function automatic int slot_limit();
		int n;
		n = int'(active_slots_cfg);
		if (n < 1)
			n = 1;
		if (n > SLOT_CNT)
			n = SLOT_CNT;
		return n;
	endfunction

	// Applies one request to the shadow state and returns the grant it must produce.
	function automatic grant_t next_fit_grant(logic mode, logic [IDX_W-1:0] idx);
		grant_t g;
		int n, p, k;
		bit found;
		g.granted_slot = '0;
		g.status = STAT_OK;
		found = 1'b0;
		if (mode == MODE_ALLOC) begin
			n = slot_limit();
			// A hint left beyond a lowered table size restarts the search at slot 0.
			p = (next_hint < n) ? next_hint : 0;
			k = 0;
			while (!found && k < n) begin
				if (!slot_taken[p]) begin
					found = 1'b1;
				end else begin
					p = (p + 1 >= n) ? 0 : p + 1;
					k++;
				end
			end
			if (found) begin
				slot_taken[p] = 1'b1;
				next_hint = (p + 1 >= n) ? 0 : p + 1;
				taken_count++;
				g.granted_slot = IDX_W'(p);
			end else begin
				g.status = STAT_FULL;
			end
		end else begin
			// Slots above the table size that are still marked are freed like any other.
			if (slot_taken[idx]) begin
				slot_taken[idx] = 1'b0;
				if (int'(idx) < next_hint)
					next_hint = int'(idx);
				if (taken_count > 0)
					taken_count--;
			end else begin
				g.status = STAT_NOT_USED;
			end
		end
		g.used_count = COUNT_W'(taken_count);
		return g;
	endfunction

	// Gap length between transactions: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(16, 40);
	endfunction

	task automatic report_error(string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// Request driver. A transaction that has not been accepted is held unchanged;
	// otherwise the driver idles out its gap or presents the next queued request.
	// A request flagged to wait for a drain stays queued until every earlier
	// request has been answered.
	always @(negedge clk) begin
		if (!arst_n || (req_if.valid && !req_taken)) begin
		end else if (req_gap > 0) begin
			req_gap--;
			req_if.valid <= 1'b0;
		end else if (request_queue.size() != 0 &&
				!(request_queue[0].hold_for_drain && in_flight != 0)) begin
			cur_req = request_queue.pop_front();
			in_flight++;
			req_if.valid <= 1'b1;
			req_if.mode <= cur_req.mode;
			req_if.slot_index <= cur_req.slot_index;
			if (req_calm > 0) begin
				req_calm--;
				req_gap = 0;
			end else begin
				if ($urandom_range(29) == 0)
					req_calm = $urandom_range(30, 90);
				req_gap = idle_len();
			end
		end else begin
			req_if.valid <= 1'b0;
		end
	end

	// Response stalls: random holds of ready, with calm stretches where it stays high.
	always @(negedge clk) begin
		if (rsp_hold > 0) begin
			rsp_hold--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= arst_n;
			if (rsp_calm > 0)
				rsp_calm--;
			else if ($urandom_range(39) == 0)
				rsp_calm = $urandom_range(30, 90);
			else if ($urandom_range(2) == 0)
				rsp_hold = idle_len();
		end
	end

	// Monitor. Both channels are sampled at the rising edge, before the block's
	// own outputs update. A response is checked against the oldest prediction
	// first; a request accepted at the same edge is predicted after that.
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = req_if.valid && req_if.ready;
			if (rsp_if.valid && rsp_if.ready) begin
				got_grant.granted_slot = rsp_if.granted_slot;
				got_grant.status = rsp_if.status;
				got_grant.used_count = rsp_if.used_count;
				if (grant_queue.size() == 0) begin
					report_error($sformatf("response with none outstanding: slot %0d status %0d",
						got_grant.granted_slot, got_grant.status));
				end else begin
					want_grant = grant_queue.pop_front();
					in_flight--;
					if (got_grant.granted_slot !== want_grant.granted_slot)
						report_error($sformatf("granted_slot %0d, expected %0d",
							got_grant.granted_slot, want_grant.granted_slot));
					if (got_grant.status !== want_grant.status)
						report_error($sformatf("status %0d, expected %0d",
							got_grant.status, want_grant.status));
					if (got_grant.used_count !== want_grant.used_count)
						report_error($sformatf("used_count %0d, expected %0d",
							got_grant.used_count, want_grant.used_count));
				end
			end
			if (req_taken)
				grant_queue.push_back(next_fit_grant(req_if.mode, req_if.slot_index));
		end
	end

	// Waits until nothing is queued or outstanding, then lets the block settle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || in_flight != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_request(logic mode, logic [IDX_W-1:0] idx, bit hold = 1'b0);
		request_t r;
		r.mode = mode;
		r.slot_index = idx;
		r.hold_for_drain = hold;
		while (request_queue.size() >= 2)
			@(negedge clk);
		request_queue.push_back(r);
	endtask

	// Writes the table size register while the block is idle. The unused upper
	// data bits carry junk half of the time; the register keeps only its 9 bits.
	task automatic write_active_slots(logic [CFG_W-1:0] value);
		wait_idle();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ACTIVE_SLOTS_ADDR;
		pwdata = PDATA_W'(value);
		if ($urandom_range(1))
			pwdata[PDATA_W-1:CFG_W] = (PDATA_W - CFG_W)'($urandom);
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		active_slots_cfg = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic int first_taken_from(int start);
		for (int i = 0; i < SLOT_CNT; i++)
			if (slot_taken[(start + i) % SLOT_CNT])
				return (start + i) % SLOT_CNT;
		return -1;
	endfunction

	// Draws one random request from the current shadow state. Most frees target
	// a slot in use; the rest hit random slots or slots around the table edge.
	task automatic queue_random_request(int alloc_pct);
		logic [IDX_W-1:0] idx;
		int r, pick;
		while (request_queue.size() >= 2)
			@(negedge clk);
		idx = IDX_W'($urandom);
		if ($urandom_range(99) < alloc_pct) begin
			queue_request(MODE_ALLOC, idx, $urandom_range(59) == 0);
		end else begin
			r = $urandom_range(99);
			if (r < 70) begin
				pick = first_taken_from($urandom_range(SLOT_CNT - 1));
				if (pick >= 0)
					idx = IDX_W'(pick);
			end else if (r < 85) begin
				idx = IDX_W'(slot_limit() + $urandom_range(3) - 2);
			end
			queue_request(MODE_FREE, idx, $urandom_range(59) == 0);
		end
	endtask

	initial begin
		int corner_slots [$];
		int phase, phase_len, alloc_pct, issued;
		logic [CFG_W-1:0] slots;

		corner_slots = '{511, 1, 0, 2, 33, 32, 256, 257, 255, 64, 7};
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.mode = MODE_ALLOC;
		req_if.slot_index = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < SLOT_CNT; i++)
			slot_taken[i] = 1'b0;
		next_hint = 0;
		taken_count = 0;
		active_slots_cfg = ACTIVE_SLOTS_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, from the reset size of 256 slots. Freeing an empty table,
		// first allocations, the hint pulled down by a free, and a double free.
		queue_request(MODE_FREE, 8'd0);
		queue_request(MODE_FREE, 8'd255);
		queue_request(MODE_ALLOC, 8'd255);
		queue_request(MODE_ALLOC, 8'd0);
		queue_request(MODE_ALLOC, 8'd128);
		queue_request(MODE_FREE, 8'd1);
		queue_request(MODE_ALLOC, 8'd0);
		queue_request(MODE_FREE, 8'd1);
		queue_request(MODE_FREE, 8'd1);
		// Three slots: the last one goes, then the table is full.
		write_active_slots(9'd3);
		queue_request(MODE_ALLOC, 8'd0);
		queue_request(MODE_ALLOC, 8'd0);
		// A size of zero acts as one slot. Slot 2 lies beyond it but is still
		// marked, so freeing it succeeds.
		write_active_slots(9'd0);
		queue_request(MODE_ALLOC, 8'd0);
		queue_request(MODE_FREE, 8'd2);
		queue_request(MODE_FREE, 8'd0);
		queue_request(MODE_ALLOC, 8'd0);
		queue_request(MODE_ALLOC, 8'd0);
		// Push the hint up, then shrink the table below it: the search restarts at 0.
		write_active_slots(9'd256);
		repeat (4) queue_request(MODE_ALLOC, 8'd0);
		write_active_slots(9'd2);
		queue_request(MODE_ALLOC, 8'd0);
		queue_request(MODE_FREE, 8'd255);
		queue_request(MODE_FREE, 8'd1);
		queue_request(MODE_ALLOC, 8'd0, 1'b1);

		// Random phases. The table state carries over from phase to phase, so
		// shrinking the size strands marked slots and hints beyond the new edge.
		// Corner phases at a size of 255 or more are long and allocation heavy to fill the table.
		issued = 0;
		phase = 0;
		while (issued < RANDOM_ITEMS) begin
			if (phase < corner_slots.size()) begin
				slots = CFG_W'(corner_slots[phase]);
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: slots = CFG_W'($urandom_range(1, 40));
					5, 6, 7, 8:    slots = CFG_W'($urandom_range(41, 256));
					default:       slots = CFG_W'($urandom_range(0, 511));
				endcase
			end
			write_active_slots(slots);
			if (slots >= 9'd255 && phase < corner_slots.size()) begin
				phase_len = 320;
				alloc_pct = 90;
			end else begin
				phase_len = $urandom_range(60, 140);
				case ($urandom_range(3))
					0:       alloc_pct = 35;
					1:       alloc_pct = 55;
					2:       alloc_pct = 75;
					default: alloc_pct = 90;
				endcase
			end
			repeat (phase_len)
				queue_random_request(alloc_pct);
			issued += phase_len;
			phase++;
		end

		wait_idle();
		if (grant_queue.size() != 0)
			report_error($sformatf("%0d responses never arrived", grant_queue.size()));
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog, far above the slowest correct run with every stall at its longest.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
